// ===== rtl/kcsp_pkg.sv =====
package kcsp_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_MOD,
    S_IDX,
    S_SQ,
    S_SQW,
    S_CUBE,
    S_CUBEW,
    S_WGT,
    S_ROW,
    S_DRAIN,
    S_OUT,
    S_STAT
  } kcsp_state_t;

  // result status codes
  localparam logic [1:0] ST_ROW    = 2'd0;
  localparam logic [1:0] ST_FINISH = 2'd1;
  localparam logic [1:0] ST_NOSEQ  = 2'd2;

  // input item kinds
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_PERIOD = 2'd0;
  localparam logic [1:0] CFG_COUNT  = 2'd1;
  localparam logic [1:0] CFG_REPEAT = 2'd2;

  // fixed field widths
  localparam int COMP_W    = 32;
  localparam int DIVISOR_W = 24;

endpackage

// ===== rtl/kcsp_div.sv =====
module kcsp_div import kcsp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [COMP_W+FRAC_BITS-1:0] dividend,
  input  logic [DIVISOR_W-1:0]        divisor,
  input  logic [$clog2(COMP_W+FRAC_BITS+1)-1:0] steps,
  output logic                        done,
  output logic [COMP_W+FRAC_BITS-1:0] quot,
  output logic [DIVISOR_W-1:0]        rem
);

  localparam int DW = COMP_W + FRAC_BITS;
  localparam int SW = $clog2(DW + 1);

  logic              busy;
  logic [SW-1:0]     cnt;
  logic [DIVISOR_W-1:0] dsr;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   trial;

  // one restoring step per cycle, dividend bits enter msb first
  assign shifted = {rem, quot[DW-1]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
        dsr  <= divisor;
        quot <= dividend;
        rem  <= '0;
      end else if (busy) begin
        if (!trial[DIVISOR_W]) begin
          rem  <= trial[DIVISOR_W-1:0];
          quot <= {quot[DW-2:0], 1'b1};
        end else begin
          rem  <= shifted[DIVISOR_W-1:0];
          quot <= {quot[DW-2:0], 1'b0};
        end
        cnt <= cnt - SW'(1);
        if (cnt == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/kcsp_mac.sv =====
module kcsp_mac import kcsp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  input  logic                                     in_first,
  input  logic signed [COMP_W-1:0]                 a0,
  input  logic signed [COMP_W-1:0]                 a1,
  input  logic signed [COMP_W-1:0]                 a2,
  input  logic signed [FRAC_BITS+3:0]              b,
  output logic signed [COMP_W+FRAC_BITS+5:0]       acc0,
  output logic signed [COMP_W+FRAC_BITS+5:0]       acc1,
  output logic signed [COMP_W+FRAC_BITS+5:0]       acc2
);

  localparam int PW = COMP_W + FRAC_BITS + 4;

  logic signed [PW-1:0] prod0, prod1, prod2;
  logic                 prod_valid, prod_first;

  // three component lanes share one weight, product registered before the add
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      prod_first <= 1'b0;
    end else begin
      prod_valid <= in_valid;
      prod_first <= in_first;
    end
  end

  always_ff @(posedge clk) begin
    prod0 <= a0 * b;
    prod1 <= a1 * b;
    prod2 <= a2 * b;
  end

  // accumulate, restarting on the first product of a sum
  always_ff @(posedge clk) begin
    if (prod_valid) begin
      if (prod_first) begin
        acc0 <= (PW+2)'(prod0);
        acc1 <= (PW+2)'(prod1);
        acc2 <= (PW+2)'(prod2);
      end else begin
        acc0 <= acc0 + (PW+2)'(prod0);
        acc1 <= acc1 + (PW+2)'(prod1);
        acc2 <= acc2 + (PW+2)'(prod2);
      end
    end
  end

endmodule

// ===== rtl/keyframe_camera_spline_player.sv =====
// operation: a load item writes the keyframe store; a tick item divides the elapsed time
//   (32 + FRAC_BITS quotient bits), wraps the frame modulo the keyframe count when it runs
//   over, sets up weights, then computes each row on the shared multiply-accumulate unit
// throughput: one item at a time, the next item accepted once the last row is registered;
//   status results are registered from S_STAT, entered on accept or on a divider finish
// reset: synchronous, clears elapsed time and finished flag, passes to one, registers
//   to their defaults; keyframe store contents are undefined until loaded
module keyframe_camera_spline_player import kcsp_pkg::*; #(
  parameter int MAX_KEYFRAMES = 256,
  parameter int FRAC_BITS     = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // key_index, row_index, load_x, load_y, load_z, time_delta, zero fill
  input  logic [127:0] s_axis_tdata,
  // func
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_row, out_x, out_y, out_z, zero fill
  output logic [103:0] m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_wdata
);

  localparam int IW   = $clog2(MAX_KEYFRAMES);
  localparam int AW   = IW + 2;
  localparam int WW   = FRAC_BITS + 4;
  localparam int DW   = COMP_W + FRAC_BITS;
  localparam int SW   = $clog2(DW + 1);
  localparam int ACCW = COMP_W + FRAC_BITS + 6;
  localparam int DEPTH = MAX_KEYFRAMES * 4;

  // configuration and playback state
  logic [23:0] frame_period;
  logic [8:0]  keyframe_count;
  logic [31:0] elapsed;
  logic [15:0] passes;
  logic        finished;

  kcsp_state_t state, state_next;

  logic [FRAC_BITS-1:0] tval, t2, t3;
  logic [IW-1:0]        idx [4];
  logic signed [WW-1:0] w   [4];
  logic [1:0]           row;
  logic [2:0]           cnt;
  logic [1:0]           stat_code;
  logic                 d1_valid, d1_first;
  logic [1:0]           d1_i;

  logic [3*COMP_W-1:0]  mem [DEPTH];
  logic [3*COMP_W-1:0]  rd_data;
  logic [AW-1:0]        rd_addr;

  // input fields
  logic [7:0]  in_key;
  logic [1:0]  in_row;
  logic [95:0] in_xyz;
  logic [15:0] in_delta;
  assign in_key   = s_axis_tdata[7:0];
  assign in_row   = s_axis_tdata[9:8];
  assign in_xyz   = s_axis_tdata[105:10];
  assign in_delta = s_axis_tdata[121:106];

  logic accept, out_free;
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // effective period and keyframe count
  logic [23:0] period;
  logic [31:0] count32, kc32, max32;
  assign period  = (frame_period == 24'd0) ? 24'd1 : frame_period;
  assign kc32    = 32'(keyframe_count);
  assign max32   = 32'(MAX_KEYFRAMES);
  assign count32 = (kc32 > max32) ? max32 : kc32;

  // saturating elapsed time
  logic [32:0] esum;
  logic [31:0] elap_new;
  assign esum     = {1'b0, elapsed} + 33'(in_delta);
  assign elap_new = esum[32] ? 32'hFFFF_FFFF : esum[31:0];

  // divider
  logic                 div_start, div_done;
  logic [DW-1:0]        div_dividend, div_quot;
  logic [DIVISOR_W-1:0] div_divisor, div_rem;
  logic [SW-1:0]        div_steps;
  logic [31:0]          frame;
  assign frame = div_quot[DW-1:FRAC_BITS];

  always_comb begin
    if (state == S_IDLE) begin
      div_dividend = {elap_new, {FRAC_BITS{1'b0}}};
      div_divisor  = period;
      div_steps    = SW'(DW);
    end else begin
      div_dividend = {frame, {FRAC_BITS{1'b0}}};
      div_divisor  = DIVISOR_W'(count32);
      div_steps    = SW'(COMP_W);
    end
  end

  kcsp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // multiply-accumulate operand selection
  logic                       mac_valid, mac_first, use_t;
  logic signed [COMP_W-1:0]   mac_a0, mac_a1, mac_a2;
  logic signed [WW-1:0]       mac_b;
  logic signed [ACCW-1:0]     acc0, acc1, acc2;

  assign use_t     = (state == S_SQ) || (state == S_CUBE);
  assign mac_valid = use_t || d1_valid;
  assign mac_first = use_t || d1_first;

  always_comb begin
    if (use_t) begin
      mac_a0 = (state == S_SQ) ? signed'(COMP_W'(tval)) : signed'(COMP_W'(t2));
      mac_a1 = '0;
      mac_a2 = '0;
      mac_b  = signed'(WW'(tval));
    end else begin
      mac_a0 = signed'(rd_data[31:0]);
      mac_a1 = signed'(rd_data[63:32]);
      mac_a2 = signed'(rd_data[95:64]);
      mac_b  = w[d1_i];
    end
  end

  kcsp_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mac_valid),
    .in_first (mac_first),
    .a0       (mac_a0),
    .a1       (mac_a1),
    .a2       (mac_a2),
    .b        (mac_b),
    .acc0     (acc0),
    .acc1     (acc1),
    .acc2     (acc2)
  );

  // keyframe store, one row of three components per entry
  logic [31:0] key32;
  logic        mem_we;
  assign key32   = 32'(in_key);
  assign mem_we  = accept && (s_axis_tuser == FUNC_LOAD) && (key32 < max32);
  assign rd_addr = {idx[cnt[1:0]], row};

  always_ff @(posedge clk) begin
    if (mem_we) mem[{key32[IW-1:0], in_row}] <= in_xyz;
    rd_data <= mem[rd_addr];
  end

  // round half up, drop the doubled-weight scale, saturate
  function automatic logic [31:0] round_sat(input logic signed [ACCW-1:0] s);
    logic signed [ACCW-1:0] half, sh, hi, lo;
    half = ACCW'(1) << FRAC_BITS;
    hi   = ACCW'(32'sh7FFF_FFFF);
    lo   = ~hi;
    sh   = (s + half) >>> (FRAC_BITS + 1);
    if (sh > hi) return 32'h7FFF_FFFF;
    if (sh < lo) return 32'h8000_0000;
    return sh[31:0];
  endfunction

  // index wrap for the following keyframes
  logic [IW-1:0] idx_n [1:3];
  always_comb begin
    logic [31:0] n;
    n = 32'(idx[0]) + 32'd1;
    idx_n[1] = (n == count32) ? '0 : n[IW-1:0];
    n = 32'(idx_n[1]) + 32'd1;
    idx_n[2] = (n == count32) ? '0 : n[IW-1:0];
    n = 32'(idx_n[2]) + 32'd1;
    idx_n[3] = (n == count32) ? '0 : n[IW-1:0];
  end

  // catmull-rom doubled weights
  logic signed [WW-1:0] tv, q2, q3;
  assign tv = signed'(WW'(tval));
  assign q2 = signed'(WW'(t2));
  assign q3 = signed'(WW'(t3));

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept && s_axis_tuser == FUNC_TICK) begin
          if (count32 == 32'd0 || finished) begin
            state_next = S_STAT;
          end else begin
            state_next = S_DIV;
            div_start  = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (frame >= count32) begin
            if (passes <= 16'd1) begin
              state_next = S_STAT;
            end else begin
              state_next = S_MOD;
              div_start  = 1'b1;
            end
          end else begin
            state_next = S_IDX;
          end
        end
      end
      S_MOD:   if (div_done) state_next = S_IDX;
      S_IDX:   state_next = S_SQ;
      S_SQ:    state_next = S_SQW;
      S_SQW:   if (cnt == 3'd1) state_next = S_CUBE;
      S_CUBE:  state_next = S_CUBEW;
      S_CUBEW: if (cnt == 3'd1) state_next = S_WGT;
      S_WGT:   state_next = S_ROW;
      S_ROW:   if (cnt == 3'd3) state_next = S_DRAIN;
      S_DRAIN: if (cnt == 3'd2) state_next = S_OUT;
      S_OUT: begin
        if (out_free) state_next = (row == 2'd3) ? S_IDLE : S_ROW;
      end
      S_STAT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period   <= 24'd1000;
      keyframe_count <= 9'd0;
      elapsed        <= '0;
      passes         <= 16'd1;
      finished       <= 1'b0;
      m_axis_tvalid  <= 1'b0;
      d1_valid       <= 1'b0;
      cnt            <= '0;
      row            <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PERIOD: frame_period <= cfg_wdata;
          CFG_COUNT:  keyframe_count <= cfg_wdata[8:0];
          CFG_REPEAT: begin
            passes   <= (cfg_wdata[15:0] == 16'd0) ? 16'd1 : cfg_wdata[15:0];
            finished <= 1'b0;
          end
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      d1_valid <= (state == S_ROW);
      d1_first <= (state == S_ROW) && (cnt == 3'd0);
      d1_i     <= cnt[1:0];
      case (state)
        S_IDLE: begin
          if (accept && s_axis_tuser == FUNC_TICK) begin
            if (count32 == 32'd0) begin
              stat_code <= ST_NOSEQ;
            end else if (finished) begin
              stat_code <= ST_FINISH;
            end else begin
              elapsed <= elap_new;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            tval <= div_quot[FRAC_BITS-1:0];
            if (frame >= count32) begin
              passes <= (passes == 16'd0) ? 16'd0 : passes - 16'd1;
              if (passes <= 16'd1) begin
                finished  <= 1'b1;
                stat_code <= ST_FINISH;
              end else begin
                elapsed <= '0;
              end
            end else begin
              idx[0] <= frame[IW-1:0];
            end
          end
        end
        S_MOD: if (div_done) idx[0] <= div_rem[IW-1:0];
        S_IDX: begin
          idx[1] <= idx_n[1];
          idx[2] <= idx_n[2];
          idx[3] <= idx_n[3];
          cnt    <= '0;
        end
        S_SQW: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd1) begin
            t2  <= acc0[2*FRAC_BITS-1:FRAC_BITS];
            cnt <= '0;
          end
        end
        S_CUBEW: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd1) begin
            t3  <= acc0[2*FRAC_BITS-1:FRAC_BITS];
            cnt <= '0;
          end
        end
        S_WGT: begin
          w[0] <= (q2 <<< 1) - q3 - tv;
          w[1] <= q3 + (q3 <<< 1) - (q2 <<< 2) - q2 + (WW'(1) <<< (FRAC_BITS + 1));
          w[2] <= (q2 <<< 2) + tv - q3 - (q3 <<< 1);
          w[3] <= q3 - q2;
          row  <= '0;
          cnt  <= '0;
        end
        S_ROW: cnt <= (cnt == 3'd3) ? 3'd0 : cnt + 3'd1;
        S_DRAIN: cnt <= (cnt == 3'd2) ? 3'd0 : cnt + 3'd1;
        S_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= ST_ROW;
            m_axis_tlast  <= (row == 2'd3);
            m_axis_tdata  <= {6'd0, round_sat(acc2), round_sat(acc1),
                              round_sat(acc0), row};
            row <= row + 2'd1;
            cnt <= '0;
          end
        end
        S_STAT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= stat_code;
            m_axis_tlast  <= 1'b1;
            m_axis_tdata  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== test/tb_keyframe_camera_spline_player.sv =====
module tb_keyframe_camera_spline_player;
  import kcsp_pkg::*;

  localparam int NKEY = 256;
  localparam int FB = 16;

  typedef struct packed {
    logic        func;
    logic [7:0]  key;
    logic [1:0]  row;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [15:0] dt;
  } cam_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  row;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
  } cam_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_PERIOD;
  logic [23:0] cfg_wdata = '0;

  keyframe_camera_spline_player dut (.*);

  always #4 clk = ~clk;

  // predictor state
  logic [31:0] key_mem [0:NKEY*12-1];
  logic [31:0] elapsed;
  logic [15:0] passes;
  logic        done_flag;
  logic [23:0] period_reg;
  logic [8:0]  count_reg;
  logic [15:0] repeat_reg;

  cam_item_t pending_items[$];
  cam_row_t  expected_rows[$];
  bit        started = 1'b0;
  int        fails = 0;
  int        send_gap = 0;
  int        recv_gap = 0;
  int        quiet = 0;

  task automatic expect_row(input cam_row_t r);
    expected_rows.insert(expected_rows.size(), r);
  endtask

  task automatic queue_item(input cam_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic longint rnd_shift(longint s);
    longint v;
    v = s + (64'sd1 <<< FB);
    return v >>> (FB + 1);
  endfunction

  function automatic logic [31:0] sat(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // work out the rows a tick item should produce
  task automatic predict_tick(input logic [15:0] dt);
    int unsigned cnt, per, frame, rem, idx[4];
    longint unsigned e, t, t2, t3;
    longint a[4], s;
    logic [31:0] res[3];
    cam_row_t r;
    cnt = (count_reg > NKEY) ? NKEY : count_reg;
    if (cnt == 0) begin
      expect_row('{ST_NOSEQ, 2'd0, 32'd0, 32'd0, 32'd0, 1'b1});
      return;
    end
    if (done_flag) begin
      expect_row('{ST_FINISH, 2'd0, 32'd0, 32'd0, 32'd0, 1'b1});
      return;
    end
    e = longint'(elapsed) + dt;
    elapsed = (e > 64'hffffffff) ? 32'hffffffff : e[31:0];
    per = (period_reg == 0) ? 1 : period_reg;
    frame = elapsed / per;
    rem = elapsed % per;
    t = (longint'(rem) << FB) / per;
    if (frame >= cnt) begin
      if (passes > 0) passes--;
      if (passes == 0) begin
        done_flag = 1'b1;
        expect_row('{ST_FINISH, 2'd0, 32'd0, 32'd0, 32'd0, 1'b1});
        return;
      end
      elapsed = 0;
    end
    idx[0] = frame % cnt;
    for (int i = 1; i < 4; i++) idx[i] = (idx[i-1] + 1) % cnt;
    t2 = (t * t) >> FB;
    t3 = (t2 * t) >> FB;
    a[0] = -longint'(t3) + 2 * longint'(t2) - longint'(t);
    a[1] = 3 * longint'(t3) - 5 * longint'(t2) + 2 * (64'sd1 <<< FB);
    a[2] = -3 * longint'(t3) + 4 * longint'(t2) + longint'(t);
    a[3] = longint'(t3) - longint'(t2);
    for (int rr = 0; rr < 4; rr++) begin
      for (int c = 0; c < 3; c++) begin
        s = 0;
        for (int i = 0; i < 4; i++)
          s += longint'(signed'(key_mem[(idx[i]*4 + rr)*3 + c])) * a[i];
        res[c] = sat(rnd_shift(s));
      end
      r = '{ST_ROW, rr[1:0], res[0], res[1], res[2], rr == 3};
      expect_row(r);
    end
  endtask

  task automatic predict(input cam_item_t it);
    if (it.func == FUNC_LOAD) begin
      key_mem[(it.key*4 + it.row)*3]     = it.x;
      key_mem[(it.key*4 + it.row)*3 + 1] = it.y;
      key_mem[(it.key*4 + it.row)*3 + 2] = it.z;
    end else begin
      predict_tick(it.dt);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict(pending_items.pop_front());
        send_gap <= $urandom_range(0, 9);
        s_axis_tvalid <= 1'b0;
      end else if (!s_axis_tvalid && started && pending_items.size() > 0) begin
        if (send_gap > 0) send_gap <= send_gap - 1;
        else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= pending_items[0].func;
          s_axis_tdata <= {6'd0, pending_items[0].dt, pending_items[0].z,
                           pending_items[0].y, pending_items[0].x,
                           pending_items[0].row, pending_items[0].key};
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cam_row_t got, want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tuser, m_axis_tdata[1:0], m_axis_tdata[33:2],
                m_axis_tdata[65:34], m_axis_tdata[97:66], m_axis_tlast};
        if (expected_rows.size() == 0) begin
          $error("row with nothing expected");
          fails++;
        end else begin
          want = expected_rows.pop_front();
          if (got.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, got.status); fails++;
          end
          if (got.row !== want.row) begin
            $error("out_row exp %0d got %0d", want.row, got.row); fails++;
          end
          if (got.x !== want.x) begin
            $error("out_x exp %h got %h", want.x, got.x); fails++;
          end
          if (got.y !== want.y) begin
            $error("out_y exp %h got %h", want.y, got.y); fails++;
          end
          if (got.z !== want.z) begin
            $error("out_z exp %h got %h", want.z, got.z); fails++;
          end
          if (got.last !== want.last) begin
            $error("last exp %0d got %0d", want.last, got.last); fails++;
          end
        end
        recv_gap <= $urandom_range(0, 9);
        m_axis_tready <= 1'b0;
      end else if (!m_axis_tready) begin
        if (recv_gap > 0) recv_gap <= recv_gap - 1;
        else m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_rows.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PERIOD) period_reg = val;
    else if (idx == CFG_COUNT) count_reg = val[8:0];
    else begin
      repeat_reg = val[15:0];
      passes = (repeat_reg == 0) ? 16'd1 : repeat_reg;
      done_flag = 1'b0;
    end
    @(posedge clk);
  endtask

  function automatic cam_item_t load_item(int k, int r, logic [31:0] x, logic [31:0] y,
                                          logic [31:0] z);
    cam_item_t it;
    it = '{FUNC_LOAD, k[7:0], r[1:0], x, y, z, 16'($urandom)};
    return it;
  endfunction

  function automatic cam_item_t tick_item(logic [15:0] dt);
    cam_item_t it;
    it = '{FUNC_TICK, 8'($urandom), 2'($urandom), $urandom, $urandom, $urandom, dt};
    return it;
  endfunction

  // every row of keys first..first+n-1 loaded with random or extreme content
  task automatic load_keys(int first, int n, bit extreme);
    logic [31:0] v[3];
    for (int k = first; k < first + n; k++)
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++)
          v[c] = extreme ? (($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000)
                         : (($urandom_range(0, 3) == 0) ? $urandom
                                                        : 32'($signed($urandom_range(0, 2**20)) - 2**19));
        queue_item(load_item(k, r, v[0], v[1], v[2]));
      end
  endtask

  task automatic run_ticks(int n, int dmax);
    for (int i = 0; i < n; i++) queue_item(tick_item(16'($urandom_range(0, dmax))));
  endtask

  initial begin
    int wrap_period, wrap_dmax;
    period_reg = 24'd1000;
    count_reg = 9'd0;
    repeat_reg = 16'd1;
    passes = 16'd1;
    done_flag = 1'b0;
    elapsed = 32'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    started = 1'b1;

    // no sequence, then extreme keyframes with saturating sums
    queue_item(tick_item(16'hffff));
    load_keys(0, 4, 1'b1);
    queue_item(load_item(255, 3, 32'hffffffff, 32'h0, 32'h80000000));
    wait_idle();
    write_reg(CFG_COUNT, 24'd4);
    write_reg(CFG_PERIOD, 24'd1);
    write_reg(CFG_REPEAT, 24'd0);
    queue_item(tick_item(16'd0));
    queue_item(tick_item(16'd2));
    queue_item(tick_item(16'd5));
    queue_item(tick_item(16'd0));
    wait_idle();

    // smooth fractions, wrap and repeat
    write_reg(CFG_PERIOD, 24'd700);
    write_reg(CFG_REPEAT, 24'd3);
    load_keys(0, 6, 1'b0);
    wait_idle();
    write_reg(CFG_COUNT, 24'd6);
    run_ticks(40, 400);
    wait_idle();

    // largest period: always frame zero
    write_reg(CFG_PERIOD, 24'hffffff);
    write_reg(CFG_REPEAT, 24'hffff);
    run_ticks(20, 65535);
    wait_idle();

    // count above the store depth acts as the full store, wrap from key 255 to key 0
    write_reg(CFG_COUNT, 24'd300);
    write_reg(CFG_REPEAT, 24'd2);
    load_keys(254, 2, 1'b0);
    wait_idle();
    wrap_period = elapsed / 254;
    if (wrap_period == 0) wrap_period = 1;
    wrap_dmax = wrap_period / 8;
    if (wrap_dmax > 65535) wrap_dmax = 65535;
    write_reg(CFG_PERIOD, 24'(wrap_period));
    run_ticks(24, wrap_dmax);
    wait_idle();

    // mixed random loads and ticks over a short sequence
    write_reg(CFG_COUNT, 24'd5);
    write_reg(CFG_PERIOD, 24'($urandom_range(1, 5000)));
    write_reg(CFG_REPEAT, 24'd4);
    for (int i = 0; i < 140; i++) begin
      if ($urandom_range(0, 3) == 0)
        queue_item(load_item($urandom_range(0, 255), $urandom_range(0, 3),
                             $urandom, $urandom, $urandom));
      else queue_item(tick_item(16'($urandom_range(0, 3000))));
    end
    wait_idle();
    write_reg(CFG_COUNT, 24'd0);
    run_ticks(3, 65535);
    wait_idle();

    if (fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/kcsp_pkg.sv
rtl/kcsp_div.sv
rtl/kcsp_mac.sv
rtl/keyframe_camera_spline_player.sv
test/tb_keyframe_camera_spline_player.sv
